[hw/rtl/command_frame_to_servo_duty_assert.svh]
// Assertion macros shared by the RTL of the command frame decoder.
`ifndef COMMAND_FRAME_TO_SERVO_DUTY_ASSERT_SVH
`define COMMAND_FRAME_TO_SERVO_DUTY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CFSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfsd assertion failed");

// next-cycle implication
`define CFSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfsd assertion failed");

`else

`define CFSD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CFSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/cfsd_pkg.sv]
package cfsd_pkg;

   // framing bytes
   localparam logic [7:0] START_BYTE = 8'h3C;
   localparam logic [7:0] END_BYTE   = 8'h3E;
   localparam logic [7:0] SENSE_BYTE = 8'h73;
   localparam logic [7:0] MID_BYTE   = 8'd127;
   localparam logic [3:0] FRAME_LAST = 4'd15;

   // channel codes
   localparam logic [3:0] CH_WHEEL_L = 4'd0;
   localparam logic [3:0] CH_WHEEL_R = 4'd1;
   localparam logic [3:0] CH_PAN     = 4'd2;
   localparam logic [3:0] CH_TILT    = 4'd3;
   localparam logic [3:0] CH_UPPER   = 4'd4;
   localparam logic [3:0] CH_LOWER   = 4'd5;
   localparam logic [3:0] CH_BASE    = 4'd6;
   localparam logic [3:0] CH_WRIST   = 4'd7;
   localparam logic [3:0] CH_YAW     = 4'd8;
   localparam logic [3:0] CH_PITCH   = 4'd9;
   localparam logic [3:0] CH_CLAW    = 4'd10;

   // register indexes
   localparam logic [1:0] CSR_CAMERA_STEP = 2'd0;
   localparam logic [1:0] CSR_PITCH_STEP  = 2'd1;
   localparam logic [1:0] CSR_PITCH_LOW   = 2'd2;
   localparam logic [1:0] CSR_PITCH_HIGH  = 2'd3;

   // reset values
   localparam logic [11:0] CAMERA_STEP_RST = 12'd66;
   localparam logic [11:0] PITCH_STEP_RST  = 12'd13;
   localparam logic [15:0] PITCH_LOW_RST   = 16'd3277;
   localparam logic [15:0] PITCH_HIGH_RST  = 16'd6554;
   localparam logic [15:0] CAMERA_DUTY_RST = 16'd4915;
   localparam logic [15:0] PITCH_DUTY_RST  = 16'd4850;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [11:0] camera_step;
      logic [11:0] pitch_step;
      logic [15:0] pitch_low;
      logic [15:0] pitch_high;
   } cfg_type;

   // one accepted frame, bytes 1..12 and the sensor flag of byte 13
   typedef struct packed {
      logic [7:0] wheel_l;
      logic [7:0] wheel_r;
      logic [7:0] pan;
      logic [7:0] tilt;
      logic [7:0] select;
      logic [7:0] upper;
      logic [7:0] lower;
      logic [7:0] base;
      logic [7:0] wrist;
      logic [7:0] yaw;
      logic [7:0] pitch;
      logic [7:0] claw;
      logic       sense;
   } frame_type;

   typedef logic [255:0][15:0] lut_type;

   function automatic logic [15:0] sat16(input longint v);
      return (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   // 0.05 + 0.05*b/255
   function automatic lut_type build_wheel();
      lut_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = sat16((longint'(65536) * (255 + i)) / 5100);
      end
      return t;
   endfunction

   // 0.10 + 0.10*b/255
   function automatic lut_type build_claw();
      lut_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = sat16((longint'(65536) * (255 + i)) / 2550);
      end
      return t;
   endfunction

   // 0.064 + 0.036*b/255
   function automatic lut_type build_wrist();
      lut_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = sat16((longint'(65536) * (16320 + 36 * i)) / 255000);
      end
      return t;
   endfunction

   // split-at-127 magnitude
   function automatic lut_type build_split();
      lut_type t;
      for (int i = 0; i < 256; i++) begin
         if (i > 127) begin
            t[i] = sat16(longint'(i - 127) * 512);
         end else begin
            t[i] = sat16((longint'(65536) * (127 - i)) / 127);
         end
      end
      return t;
   endfunction

   localparam lut_type WHEEL_LUT = build_wheel();
   localparam lut_type CLAW_LUT  = build_claw();
   localparam lut_type WRIST_LUT = build_wrist();
   localparam lut_type SPLIT_LUT = build_split();

endpackage

[hw/rtl/command_frame_to_servo_duty.sv]
// Channel   Beat                           Handshake
// req_      one serial byte (rx_byte)      req_valid / req_ready
// rsp_      one channel duty result        rsp_valid / rsp_ready
// csr_      register write (4 regs)        csr_write, no wait
//
// Bytes are taken one per cycle while the frame queue has room; a frame is 16 beats.
// For each good frame the back end first steps pan, tilt, pitch and select, then gives
// 11 result beats, so the byte side sets the sustained rate.
// The first result beat of a frame follows its end byte through the queue and the step.
// Reset (synchronous, high) returns to hunting with default duties and regs.
// A stalled result port backs up the frame queue; bytes stop only when it is full.

module command_frame_to_servo_duty #(
   parameter int unsigned QUEUE_DEPTH = cfsd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_channel,
   output logic [15:0] rsp_duty,
   output logic        rsp_direction,
   output logic        rsp_camera_select,
   output logic        rsp_sensor_request,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // config registers
   logic [11:0] camera_step_ff;
   logic [11:0] pitch_step_ff;
   logic [15:0] pitch_low_ff;
   logic [15:0] pitch_high_ff;
   cfsd_pkg::cfg_type cfg;

   // front -> queue -> back
   logic                q_full;
   logic                q_push;
   cfsd_pkg::frame_type q_push_data;
   logic                q_pop;
   cfsd_pkg::frame_type q_head;
   logic                q_head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_step_ff <= cfsd_pkg::CAMERA_STEP_RST;
         pitch_step_ff  <= cfsd_pkg::PITCH_STEP_RST;
         pitch_low_ff   <= cfsd_pkg::PITCH_LOW_RST;
         pitch_high_ff  <= cfsd_pkg::PITCH_HIGH_RST;
      end else if (csr_write) begin
         case (csr_index)
            cfsd_pkg::CSR_CAMERA_STEP: camera_step_ff <= csr_wdata[11:0];
            cfsd_pkg::CSR_PITCH_STEP:  pitch_step_ff  <= csr_wdata[11:0];
            cfsd_pkg::CSR_PITCH_LOW:   pitch_low_ff   <= csr_wdata;
            cfsd_pkg::CSR_PITCH_HIGH:  pitch_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.camera_step = camera_step_ff;
      cfg.pitch_step  = pitch_step_ff;
      cfg.pitch_low   = pitch_low_ff;
      cfg.pitch_high  = pitch_high_ff;
   end

   // framer: hunts for the start byte, checks the end byte lands at the last slot
   cfsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // accepted frames wait here while the back end drains results
   cfsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   // stepped state plus per-channel maps, one result beat per cycle while rsp_ready allows
   cfsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head               (q_head),
      .head_valid         (q_head_valid),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel        (rsp_channel),
      .rsp_duty           (rsp_duty),
      .rsp_direction      (rsp_direction),
      .rsp_camera_select  (rsp_camera_select),
      .rsp_sensor_request (rsp_sensor_request),
      .rsp_last           (rsp_last)
   );

endmodule

[hw/rtl/cfsd_front.sv]
module cfsd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output cfsd_pkg::frame_type  q_push_data
);

   logic       in_frame_ff, in_frame_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] store_ff [1:13];
   logic       accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      q_push      = 1'b0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == cfsd_pkg::START_BYTE) begin
               in_frame_in = 1'b1;
               pos_in      = 4'd1;
            end
         end else if (req_rx_byte != cfsd_pkg::END_BYTE && pos_ff != cfsd_pkg::FRAME_LAST) begin
            pos_in = pos_ff + 4'd1;
         end else begin
            in_frame_in = 1'b0;
            pos_in      = 4'd0;
            q_push      = (req_rx_byte == cfsd_pkg::END_BYTE) &&
                          (pos_ff == cfsd_pkg::FRAME_LAST);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= 4'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
   end

   // only bytes 1..13 carry anything used downstream
   always_ff @(posedge clock) begin
      for (int i = 1; i <= 13; i++) begin
         if (accept && in_frame_ff && pos_ff == 4'(i)) begin
            store_ff[i] <= req_rx_byte;
         end
      end
   end

   always_comb begin
      q_push_data.wheel_l = store_ff[1];
      q_push_data.wheel_r = store_ff[2];
      q_push_data.pan     = store_ff[3];
      q_push_data.tilt    = store_ff[4];
      q_push_data.select  = store_ff[5];
      q_push_data.upper   = store_ff[6];
      q_push_data.lower   = store_ff[7];
      q_push_data.base    = store_ff[8];
      q_push_data.wrist   = store_ff[9];
      q_push_data.yaw     = store_ff[10];
      q_push_data.pitch   = store_ff[11];
      q_push_data.claw    = store_ff[12];
      q_push_data.sense   = (store_ff[13] == cfsd_pkg::SENSE_BYTE);
   end

endmodule

[hw/rtl/cfsd_queue.sv]
`include "command_frame_to_servo_duty_assert.svh"

module cfsd_queue #(
   parameter int unsigned DEPTH = cfsd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cfsd_pkg::frame_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output cfsd_pkg::frame_type  head,
   output logic                 head_valid
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cfsd_pkg::frame_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CFSD_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `CFSD_ASSERT_IMPL(a_no_underflow, clock, reset, pop, count_ff != '0)
   `CFSD_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(DEPTH))

endmodule

[hw/rtl/cfsd_back.sv]
`include "command_frame_to_servo_duty_assert.svh"

module cfsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cfsd_pkg::cfg_type    cfg,
   input  cfsd_pkg::frame_type  head,
   input  logic                 head_valid,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [3:0]           rsp_channel,
   output logic [15:0]          rsp_duty,
   output logic                 rsp_direction,
   output logic                 rsp_camera_select,
   output logic                 rsp_sensor_request,
   output logic                 rsp_last
);

   typedef enum logic [1:0] {
      BK_UPDATE = 2'b01,
      BK_EMIT   = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [3:0]  ch_ff, ch_in;
   logic [15:0] pan_ff, pan_in;
   logic [15:0] tilt_ff, tilt_in;
   logic [15:0] pitch_ff, pitch_in;
   logic        sel_ff, sel_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_channel_ff;
   logic [15:0] rsp_duty_ff;
   logic        rsp_direction_ff;
   logic        rsp_camera_select_ff;
   logic        rsp_sensor_request_ff;
   logic        rsp_last_ff;

   logic        load;
   logic [7:0]  ch_byte;
   logic [15:0] duty_sel;
   logic        dir_sel;

   function automatic logic [15:0] add_sat(input logic [15:0] v, input logic [11:0] s);
      logic [16:0] sum;
      sum = {1'b0, v} + {5'b0, s};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic logic [15:0] sub_sat(input logic [15:0] v, input logic [11:0] s);
      return (v > {4'b0, s}) ? v - {4'b0, s} : 16'd0;
   endfunction

   function automatic logic [15:0] step_cam(input logic [15:0] v, input logic [7:0] b,
                                            input logic [11:0] s);
      logic [15:0] r;
      r = v;
      if (b > cfsd_pkg::MID_BYTE) begin
         r = add_sat(v, s);
      end else if (b < cfsd_pkg::MID_BYTE) begin
         r = sub_sat(v, s);
      end
      return r;
   endfunction

   // sequencer: advance the stepped state in BK_UPDATE, then one beat per channel in BK_EMIT
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      pan_in   = pan_ff;
      tilt_in  = tilt_ff;
      pitch_in = pitch_ff;
      sel_in   = sel_ff;
      load     = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         BK_UPDATE: begin
            if (head_valid) begin
               pan_in  = step_cam(pan_ff, head.pan, cfg.camera_step);
               tilt_in = step_cam(tilt_ff, head.tilt, cfg.camera_step);
               if (head.select <= cfsd_pkg::MID_BYTE) begin
                  sel_in = !sel_ff;
               end
               if (head.pitch < cfsd_pkg::MID_BYTE && pitch_ff < cfg.pitch_high) begin
                  pitch_in = add_sat(pitch_ff, cfg.pitch_step);
               end else if (head.pitch > cfsd_pkg::MID_BYTE && pitch_ff > cfg.pitch_low) begin
                  pitch_in = sub_sat(pitch_ff, cfg.pitch_step);
               end
               ch_in    = cfsd_pkg::CH_WHEEL_L;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load = 1'b1;
               if (ch_ff == cfsd_pkg::CH_CLAW) begin
                  q_pop    = 1'b1;
                  state_in = BK_UPDATE;
               end else begin
                  ch_in = ch_ff + 4'd1;
               end
            end
         end
         default: state_in = BK_UPDATE;
      endcase
   end

   always_comb begin
      case (ch_ff)
         cfsd_pkg::CH_WHEEL_L: ch_byte = head.wheel_l;
         cfsd_pkg::CH_WHEEL_R: ch_byte = head.wheel_r;
         cfsd_pkg::CH_UPPER:   ch_byte = head.upper;
         cfsd_pkg::CH_LOWER:   ch_byte = head.lower;
         cfsd_pkg::CH_BASE:    ch_byte = head.base;
         cfsd_pkg::CH_WRIST:   ch_byte = head.wrist;
         cfsd_pkg::CH_YAW:     ch_byte = head.yaw;
         default:              ch_byte = head.claw;
      endcase
   end

   always_comb begin
      dir_sel = 1'b0;
      case (ch_ff) inside
         cfsd_pkg::CH_WHEEL_L, cfsd_pkg::CH_WHEEL_R, cfsd_pkg::CH_YAW:
            duty_sel = cfsd_pkg::WHEEL_LUT[ch_byte];
         cfsd_pkg::CH_PAN:   duty_sel = pan_ff;
         cfsd_pkg::CH_TILT:  duty_sel = tilt_ff;
         cfsd_pkg::CH_UPPER, cfsd_pkg::CH_LOWER, cfsd_pkg::CH_BASE: begin
            duty_sel = cfsd_pkg::SPLIT_LUT[ch_byte];
            dir_sel  = (ch_byte <= cfsd_pkg::MID_BYTE);
         end
         cfsd_pkg::CH_WRIST: duty_sel = cfsd_pkg::WRIST_LUT[ch_byte];
         cfsd_pkg::CH_PITCH: duty_sel = pitch_ff;
         default:            duty_sel = cfsd_pkg::CLAW_LUT[ch_byte];
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_UPDATE;
         ch_ff        <= cfsd_pkg::CH_WHEEL_L;
         pan_ff       <= cfsd_pkg::CAMERA_DUTY_RST;
         tilt_ff      <= cfsd_pkg::CAMERA_DUTY_RST;
         pitch_ff     <= cfsd_pkg::PITCH_DUTY_RST;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         pan_ff       <= pan_in;
         tilt_ff      <= tilt_in;
         pitch_ff     <= pitch_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_channel_ff        <= ch_ff;
         rsp_duty_ff           <= duty_sel;
         rsp_direction_ff      <= dir_sel;
         rsp_camera_select_ff  <= sel_ff;
         rsp_sensor_request_ff <= head.sense;
         rsp_last_ff           <= (ch_ff == cfsd_pkg::CH_CLAW);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_direction      = rsp_direction_ff;
   assign rsp_camera_select  = rsp_camera_select_ff;
   assign rsp_sensor_request = rsp_sensor_request_ff;
   assign rsp_last           = rsp_last_ff;

   `CFSD_ASSERT_NEXT(a_state_hold, clock, reset, !(state_ff == BK_UPDATE && head_valid), $stable(pan_ff) && $stable(tilt_ff) && $stable(pitch_ff) && $stable(sel_ff))
   `CFSD_ASSERT_IMPL(a_emit_has_frame, clock, reset, state_ff == BK_EMIT, head_valid)
   `CFSD_ASSERT_IMPL(a_channel_range, clock, reset, rsp_valid_ff, rsp_channel_ff <= cfsd_pkg::CH_CLAW)
   `CFSD_ASSERT_NEXT(a_pop_restart, clock, reset, q_pop, state_ff == BK_UPDATE && rsp_last_ff)

endmodule
